>>> hdl/sle_pkg.sv
// Shared types and constants for the serial line editor.
package sle_pkg;

	localparam int LINE_DEPTH = 256;
	localparam int ADDR_W = $clog2(LINE_DEPTH);

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_BS = 8'd8;
	localparam logic [7:0] CH_DEL = 8'd127;
	localparam logic [7:0] CH_SP = 8'd32;
	localparam logic [7:0] PRINT_LO = 8'd32;
	localparam logic [7:0] PRINT_HI = 8'd126;

	localparam logic OP_RECEIVE = 1'b0;
	localparam logic OP_READ = 1'b1;
	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [8:0] CAP_MIN = 9'd2;
	localparam logic [8:0] CAP_MAX = 9'd256;

	typedef enum logic [1:0] {
		DESC_READ,
		DESC_NEWLINE,
		DESC_ERASE,
		DESC_CHAR
	} desc_code_t;

	// One accepted item's worth of results, expanded by the output stage.
	typedef struct packed {
		desc_code_t code;
		logic [7:0] data;
		logic done;
		logic [7:0] len;
	} desc_t;

endpackage

>>> hdl/serial_line_editor.sv
// Console line editor: an item is taken into a stage register, then expanded into its results.
// An item's first result passes the stage register, then the result register once that is
// free. Throughput: one item per cycle for reads and printable bytes while out_ready is high;
// line ends give two results and erases three, and the output register gives one result a
// cycle. Items with no result leave the stage register empty. Reset clears the fill count,
// the closed flag, the completed length and the pipeline; capacity returns to 256, the line
// store is not cleared.
module serial_line_editor (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [8:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic operation,
	input logic [7:0] rx_byte,
	input logic [7:0] read_index,
	output logic out_valid,
	input logic out_ready,
	output logic result_kind,
	output logic [7:0] data_byte,
	output logic line_done,
	output logic [7:0] line_length,
	output logic last
);
	import sle_pkg::*;

	logic s1_valid;
	logic s1_take;
	desc_t s1_desc;

	assign cfg_ready = 1'b1;

	sle_edit u_edit (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.rx_byte(rx_byte),
		.read_index(read_index),
		.s1_valid(s1_valid),
		.s1_desc(s1_desc),
		.s1_take(s1_take)
	);

	sle_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.s1_valid(s1_valid),
		.s1_desc(s1_desc),
		.s1_take(s1_take),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.line_done(line_done),
		.line_length(line_length),
		.last(last)
	);

endmodule

>>> hdl/sle_edit.sv
// Line state, line store and the first pipeline stage of the editor.
module sle_edit (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic [8:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic operation,
	input logic [7:0] rx_byte,
	input logic [7:0] read_index,
	output logic s1_valid,
	output sle_pkg::desc_t s1_desc,
	input logic s1_take
);
	import sle_pkg::*;

	logic [7:0] store_mem [LINE_DEPTH];
	logic [7:0] rdata_s1;
	logic hit_s1;
	desc_t desc_s1;
	logic valid_s1;

	logic [7:0] fill_q;
	logic [7:0] done_len_q;
	logic closed_q;
	logic [7:0] limit_q;

	logic accept;
	logic [7:0] cnt;
	logic [7:0] cnt_inc;
	logic is_nl;
	logic is_erase;
	logic is_print;
	logic store_en;
	logic has_result;
	logic [7:0] fill_d;
	logic [7:0] done_len_d;
	logic closed_d;
	desc_t desc_d;
	logic [8:0] cap_eff;

	assign in_ready = !valid_s1 || s1_take;
	assign accept = in_valid && in_ready;

	// A closed line is dropped by the next received byte before that byte is handled.
	assign cnt = closed_q ? 8'd0 : fill_q;
	assign is_nl = (rx_byte == CH_CR) || (rx_byte == CH_LF);
	assign is_erase = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
	assign is_print = (rx_byte >= PRINT_LO) && (rx_byte <= PRINT_HI);
	assign store_en = accept && (operation == OP_RECEIVE) && is_print && (cnt < limit_q);
	assign cnt_inc = (cnt < limit_q) ? cnt + 8'd1 : cnt;

	always_comb begin
		fill_d = fill_q;
		done_len_d = done_len_q;
		closed_d = closed_q;
		has_result = 1'b0;
		desc_d.code = DESC_READ;
		desc_d.data = rx_byte;
		desc_d.done = 1'b0;
		desc_d.len = 8'd0;
		if (operation == OP_READ) begin
			has_result = 1'b1;
		end else begin
			fill_d = cnt;
			closed_d = 1'b0;
			if (is_nl) begin
				has_result = 1'b1;
				desc_d.code = DESC_NEWLINE;
				desc_d.done = 1'b1;
				desc_d.len = cnt;
				done_len_d = cnt;
				closed_d = 1'b1;
			end else if (is_erase) begin
				if (cnt != 8'd0) begin
					has_result = 1'b1;
					desc_d.code = DESC_ERASE;
					fill_d = cnt - 8'd1;
				end
			end else if (is_print) begin
				has_result = 1'b1;
				desc_d.code = DESC_CHAR;
				fill_d = cnt_inc;
				if (cnt_inc >= limit_q) begin
					desc_d.done = 1'b1;
					desc_d.len = cnt_inc;
					done_len_d = cnt_inc;
					closed_d = 1'b1;
				end
			end
		end
	end

	// Capacity is clamped once at write time and kept as the character limit.
	always_comb begin
		cap_eff = cfg_data;
		if (cfg_data < CAP_MIN) begin
			cap_eff = CAP_MIN;
		end else if (cfg_data > CAP_MAX) begin
			cap_eff = CAP_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 8'd0;
			done_len_q <= 8'd0;
			closed_q <= 1'b0;
			limit_q <= 8'd255;
		end else begin
			if (cfg_valid) begin
				limit_q <= 8'(cap_eff - 9'd1);
			end
			if (accept) begin
				fill_q <= fill_d;
				done_len_q <= done_len_d;
				closed_q <= closed_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_d;
			hit_s1 <= closed_q && (read_index < done_len_q);
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			store_mem[cnt[ADDR_W-1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (operation == OP_READ)) begin
			rdata_s1 <= store_mem[read_index[ADDR_W-1:0]];
		end
	end

	always_comb begin
		s1_desc = desc_s1;
		if (desc_s1.code == DESC_READ) begin
			s1_desc.data = hit_s1 ? rdata_s1 : 8'd0;
		end
	end

	assign s1_valid = valid_s1;

endmodule

>>> hdl/sle_out.sv
// Result register that expands one item into its echo or read results.
module sle_out (
	input logic clk,
	input logic arst_n,
	input logic s1_valid,
	input sle_pkg::desc_t s1_desc,
	output logic s1_take,
	output logic out_valid,
	input logic out_ready,
	output logic result_kind,
	output logic [7:0] data_byte,
	output logic line_done,
	output logic [7:0] line_length,
	output logic last
);
	import sle_pkg::*;

	desc_t desc_q;
	logic [1:0] step_q;
	logic busy_q;
	logic finish;

	always_comb begin
		result_kind = KIND_ECHO;
		data_byte = desc_q.data;
		line_done = 1'b0;
		line_length = 8'd0;
		last = 1'b1;
		unique case (desc_q.code)
			DESC_READ: begin
				result_kind = KIND_READ;
			end
			DESC_NEWLINE: begin
				if (step_q == 2'd0) begin
					data_byte = CH_CR;
					last = 1'b0;
				end else begin
					data_byte = CH_LF;
					line_done = 1'b1;
					line_length = desc_q.len;
				end
			end
			DESC_ERASE: begin
				data_byte = (step_q == 2'd1) ? CH_SP : CH_BS;
				last = (step_q == 2'd2);
			end
			DESC_CHAR: begin
				line_done = desc_q.done;
				line_length = desc_q.len;
			end
			default: begin
				data_byte = desc_q.data;
			end
		endcase
	end

	assign out_valid = busy_q;
	assign finish = busy_q && out_ready && last;
	assign s1_take = s1_valid && (!busy_q || finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
		end else if (s1_take) begin
			busy_q <= 1'b1;
			step_q <= 2'd0;
		end else if (finish) begin
			busy_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			step_q <= step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			desc_q <= s1_desc;
		end
	end

endmodule

>>> tb/serial_line_editor_checker.sv
// Checker for the serial line editor: predicts echo and read results and compares them.
module serial_line_editor_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [8:0] cfg_data,
	input logic in_valid,
	input logic in_ready,
	input logic operation,
	input logic [7:0] rx_byte,
	input logic [7:0] read_index,
	input logic out_valid,
	input logic out_ready,
	input logic result_kind,
	input logic [7:0] data_byte,
	input logic line_done,
	input logic [7:0] line_length,
	input logic last,
	output int mismatches,
	output int results_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import sle_pkg::*;

	typedef struct packed {
		logic kind;
		logic [7:0] data;
		logic done;
		logic [7:0] length;
		logic last;
	} editor_result_t;

	editor_result_t owed_q[$];
	editor_result_t want;

	logic [7:0] line_copy [LINE_DEPTH];
	int unsigned fill;
	int unsigned closed_len;
	logic closed;
	logic [8:0] capacity;

	function automatic void owe(input logic kind, input logic [7:0] data, input logic done,
			input logic [7:0] length, input logic fin);
		editor_result_t r;
		r.kind = kind;
		r.data = data;
		r.done = done;
		r.length = length;
		r.last = fin;
		owed_q.push_back(r);
	endfunction

	task automatic edit_line(input logic op, input logic [7:0] b, input logic [7:0] idx);
		int unsigned cap;
		int unsigned limit;
		logic [7:0] value;
		if (op == OP_READ) begin
			value = 8'd0;
			if (closed && idx < closed_len) value = line_copy[idx];
			owe(KIND_READ, value, 1'b0, 8'd0, 1'b1);
		end else begin
			// The first byte after a completed line starts a fresh one.
			if (closed) begin
				fill = 0;
				closed = 1'b0;
			end
			if (b == CH_CR || b == CH_LF) begin
				closed_len = fill;
				closed = 1'b1;
				owe(KIND_ECHO, CH_CR, 1'b0, 8'd0, 1'b0);
				owe(KIND_ECHO, CH_LF, 1'b1, 8'(closed_len), 1'b1);
			end else if (b == CH_BS || b == CH_DEL) begin
				if (fill != 0) begin
					fill--;
					owe(KIND_ECHO, CH_BS, 1'b0, 8'd0, 1'b0);
					owe(KIND_ECHO, CH_SP, 1'b0, 8'd0, 1'b0);
					owe(KIND_ECHO, CH_BS, 1'b0, 8'd0, 1'b1);
				end
			end else if (b >= PRINT_LO && b <= PRINT_HI) begin
				cap = capacity;
				if (cap < CAP_MIN) cap = CAP_MIN;
				if (cap > CAP_MAX) cap = CAP_MAX;
				if (cap > LINE_DEPTH) cap = LINE_DEPTH;
				limit = cap - 1;
				// A line already past a lowered capacity keeps its count and still closes.
				if (fill < limit) begin
					line_copy[fill] = b;
					fill++;
				end
				if (fill >= limit) begin
					closed_len = fill;
					closed = 1'b1;
					owe(KIND_ECHO, b, 1'b1, 8'(closed_len), 1'b1);
				end else begin
					owe(KIND_ECHO, b, 1'b0, 8'd0, 1'b1);
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] expected_val,
			input logic [7:0] actual_val);
		if (actual_val !== expected_val) begin
			$display("%0t: %s expected %0d got %0d", $time, name, expected_val, actual_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			closed_len = 0;
			closed = 1'b0;
			capacity = CAP_MAX;
			owed_q.delete();
			mismatches = 0;
			results_owed = 0;
		end else begin
			if (cfg_valid && cfg_ready) capacity = cfg_data;
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					$display("%0t: expected no result, got kind %0d data %0d done %0d length %0d last %0d",
						$time, result_kind, data_byte, line_done, line_length, last);
					mismatches++;
				end else begin
					want = owed_q.pop_front();
					check_field("result_kind", 8'(want.kind), 8'(result_kind));
					check_field("data_byte", want.data, data_byte);
					check_field("line_done", 8'(want.done), 8'(line_done));
					check_field("line_length", want.length, line_length);
					check_field("last", 8'(want.last), 8'(last));
				end
			end
			if (in_valid && in_ready) edit_line(operation, rx_byte, read_index);
			results_owed = owed_q.size();
		end
	end

endmodule

>>> tb/tb_serial_line_editor.sv
// Testbench top for the serial line editor: drives items and capacity settings, gives the verdict.
module tb_serial_line_editor;
	timeunit 1ns;
	timeprecision 1ps;
	import sle_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int ITEMS_PER_SETTING = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [8:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = OP_RECEIVE;
	logic [7:0] rx_byte = '0;
	logic [7:0] read_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic result_kind;
	logic [7:0] data_byte;
	logic line_done;
	logic [7:0] line_length;
	logic last;

	int mismatches;
	int results_owed;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	logic [8:0] capacities [8];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	serial_line_editor u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.rx_byte(rx_byte),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.line_done(line_done),
		.line_length(line_length),
		.last(last)
	);

	serial_line_editor_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.rx_byte(rx_byte),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.line_done(line_done),
		.line_length(line_length),
		.last(last),
		.mismatches(mismatches),
		.results_owed(results_owed)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= stall_pct);
	end

	// Ends the run when no channel has moved an item for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_serial_line_editor failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Valid stays high between back-to-back items; it only drops for an idle gap.
	task automatic send_item(input logic op, input logic [7:0] b, input logic [7:0] idx);
		while ($urandom_range(99, 0) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= b;
		read_index <= idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [8:0] cap);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] ignored_byte();
		logic [7:0] b;
		if ($urandom_range(1, 0) != 0) begin
			b = 8'($urandom_range(255, 128));
		end else begin
			b = 8'($urandom_range(31, 0));
			if (b == CH_BS || b == CH_LF || b == CH_CR) b = 8'd27;
		end
		return b;
	endfunction

	// A typed line with some erases and stray bytes, a line end, then reads of the result.
	task automatic type_line(input int unsigned max_len);
		int unsigned n;
		int unsigned k;
		int unsigned pick;
		int unsigned i;
		n = $urandom_range(max_len, 0);
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(99, 0);
			if (pick < 84)
				send_item(OP_RECEIVE, 8'($urandom_range(PRINT_HI, PRINT_LO)),
					8'($urandom_range(255, 0)));
			else if (pick < 92)
				send_item(OP_RECEIVE, pick[0] ? CH_BS : CH_DEL, 8'($urandom_range(255, 0)));
			else
				send_item(OP_RECEIVE, ignored_byte(), 8'($urandom_range(255, 0)));
		end
		send_item(OP_RECEIVE, ($urandom_range(1, 0) != 0) ? CH_CR : CH_LF,
			8'($urandom_range(255, 0)));
		k = $urandom_range(3, 0);
		for (i = 0; i < k; i++) begin
			if ($urandom_range(3, 0) != 0)
				send_item(OP_READ, 8'($urandom_range(255, 0)), 8'($urandom_range(n, 0)));
			else
				send_item(OP_READ, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
		end
	endtask

	task automatic run_setting(input logic [8:0] cap);
		int unsigned target;
		int unsigned j;
		set_capacity(cap);
		target = items_sent + ITEMS_PER_SETTING;
		while (items_sent < target) begin
			if ($urandom_range(99, 0) < 85) begin
				type_line(24);
			end else begin
				for (j = $urandom_range(3, 1); j > 0; j--) begin
					if ($urandom_range(1, 0) != 0)
						send_item(OP_RECEIVE, ignored_byte(), 8'($urandom_range(255, 0)));
					else
						send_item(logic'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
							8'($urandom_range(255, 0)));
				end
			end
		end
	endtask

	initial begin
		int p;
		int i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at full rate.
		send_item(OP_READ, 8'd0, 8'd0);
		send_item(OP_RECEIVE, CH_BS, 8'd0);
		send_item(OP_RECEIVE, 8'd0, 8'd255);
		send_item(OP_RECEIVE, 8'd255, 8'd0);
		send_item(OP_RECEIVE, 8'd128, 8'd0);
		send_item(OP_RECEIVE, 8'd31, 8'd0);
		send_item(OP_RECEIVE, PRINT_LO, 8'd0);
		send_item(OP_RECEIVE, PRINT_HI, 8'd0);
		send_item(OP_RECEIVE, "A", 8'd0);
		send_item(OP_RECEIVE, CH_DEL, 8'd0);
		send_item(OP_RECEIVE, CH_BS, 8'd0);
		send_item(OP_RECEIVE, "Z", 8'd0);
		send_item(OP_RECEIVE, CH_CR, 8'd0);
		send_item(OP_READ, 8'd255, 8'd0);
		send_item(OP_READ, 8'd0, 8'd1);
		send_item(OP_READ, 8'd0, 8'd2);
		send_item(OP_READ, 8'd0, 8'd255);
		send_item(OP_RECEIVE, CH_LF, 8'd0);
		send_item(OP_RECEIVE, "!", 8'd0);
		send_item(OP_READ, 8'd0, 8'd0);
		send_item(OP_RECEIVE, "a", 8'd0);
		send_item(OP_RECEIVE, "b", 8'd0);
		send_item(OP_RECEIVE, "c", 8'd0);
		// Capacity drops below the current fill; the next character closes the line as is.
		set_capacity(9'd3);
		send_item(OP_RECEIVE, "q", 8'd0);
		send_item(OP_READ, 8'd0, 8'd3);

		// One full-length line at the largest capacity.
		set_capacity(CAP_MAX);
		for (i = 0; i < 255; i++)
			send_item(OP_RECEIVE, 8'($urandom_range(PRINT_HI, PRINT_LO)), 8'($urandom_range(255, 0)));
		send_item(OP_READ, 8'd0, 8'd0);
		send_item(OP_READ, 8'd0, 8'd254);
		send_item(OP_READ, 8'd0, 8'd255);
		send_item(OP_READ, 8'd0, 8'($urandom_range(254, 0)));

		capacities = '{9'd2, 9'd0, 9'd511, 9'd1, 9'd3, 9'd257, 9'd256,
			9'($urandom_range(40, 4))};
		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 72;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 72;
				end
				default: begin
					idle_pct = 20;
					stall_pct = 20;
				end
			endcase
			run_setting(capacities[2 * p]);
			run_setting(capacities[2 * p + 1]);
		end

		settle();
		if (mismatches == 0)
			$display("tb_serial_line_editor passed");
		else
			$display("tb_serial_line_editor failed");
		$finish;
	end

endmodule

>>> serial_line_editor.f
hdl/sle_pkg.sv
hdl/sle_edit.sv
hdl/sle_out.sv
hdl/serial_line_editor.sv
tb/serial_line_editor_checker.sv
tb/tb_serial_line_editor.sv
